FILE: rtl/core/pal_pkg.sv
// pal_pkg: shared widths, constants and codes of the potentiometer angle low-pass unit
// no dependencies; imported by the channel interfaces and the top level

package pal_pkg;

   // channel field widths
   localparam int SAMPLE_W  = 16;
   localparam int ELAPSED_W = 20;
   localparam int MRAD_W    = 21;
   localparam int MDEG_W    = 27;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   // shared multiplier and divider widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DVS_W  = 59;
   localparam int QUO_W  = 33;

   // fixed-point constants
   localparam logic [20:0] MRAD_PER_DEG_Q16  = 21'd1143819;
   localparam logic [21:0] MDEG_PER_MRAD_Q16 = 22'd3754936;
   localparam logic [18:0] TWO_PI_Q16        = 19'd411775;
   localparam logic [DVS_W-1:0] ALPHA_BASE   = 59'd65536000000000;
   localparam logic [QUO_W-1:0] X_CLAMP      = 33'h1_0000_0000;
   localparam logic [QUO_W-1:0] X_HALF       = 33'd32768;
   localparam logic signed [MRAD_W-1:0] ANGLE_LIMIT = 21'sd1000000;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY = 3'd0,
      CSR_SERIES = 3'd1,
      CSR_POT    = 3'd2,
      CSR_RANGE  = 3'd3,
      CSR_BIAS   = 3'd4,
      CSR_CUTOFF = 3'd5
   } csr_index_type;

endpackage

FILE: rtl/core/pal_req_if.sv
// pal_req_if: input channel carrying one divider sample word
// depends on pal_pkg for field widths

interface pal_req_if import pal_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SAMPLE_W-1:0]  sample_mv;
   logic [ELAPSED_W-1:0] elapsed_us;

   modport source (output valid, output sample_mv, output elapsed_us, input ready);
   modport sink   (input valid, input sample_mv, input elapsed_us, output ready);
endinterface

FILE: rtl/core/pal_rsp_if.sv
// pal_rsp_if: result channel carrying raw and filtered angle words
// depends on pal_pkg for field widths

interface pal_rsp_if import pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [MRAD_W-1:0] angle_mrad;
   logic signed [MRAD_W-1:0] filtered_mrad;
   logic signed [MDEG_W-1:0] angle_mdeg;
   logic signed [MDEG_W-1:0] filtered_mdeg;
   logic                     over_supply;

   modport source (output valid, output angle_mrad, output filtered_mrad,
                   output angle_mdeg, output filtered_mdeg, output over_supply,
                   input ready);
   modport sink   (input valid, input angle_mrad, input filtered_mrad,
                   input angle_mdeg, input filtered_mdeg, input over_supply,
                   output ready);
endinterface

FILE: rtl/core/pal_csr_if.sv
// pal_csr_if: configuration write channel, register index and write data
// depends on pal_pkg for field widths

interface pal_csr_if import pal_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/potentiometer_angle_lowpass_unit.sv
// An accepted req word runs the full sequence on a regular sample; the first sample after reset
// seeds the filter instead of updating it, and a sample at or above supply skips the ratio division.
// One word in flight: the next req word is taken the cycle after the result is
// registered. The 33-step and 16-step restoring divisions run on the shared subtractor, and
// the multiply steps run on the shared 33x33 multiplier.
// Reset (synchronous, active high) restores the register defaults and unseeds the filter.

module potentiometer_angle_lowpass_unit import pal_pkg::*; (
   input logic       clock,
   input logic       reset,
   pal_req_if.sink   req_ch,
   pal_rsp_if.source rsp_ch,
   pal_csr_if.sink   csr_ch
);

   typedef enum logic [19:0] {
      S_IDLE    = 20'd1 << 0,
      S_MUL_A   = 20'd1 << 1,
      S_MUL_B   = 20'd1 << 2,
      S_DIV1_LD = 20'd1 << 3,
      S_DIV1    = 20'd1 << 4,
      S_RNG     = 20'd1 << 5,
      S_ANG     = 20'd1 << 6,
      S_SAT     = 20'd1 << 7,
      S_SEED    = 20'd1 << 8,
      S_CE      = 20'd1 << 9,
      S_PLO     = 20'd1 << 10,
      S_PHI     = 20'd1 << 11,
      S_DIV2_LD = 20'd1 << 12,
      S_DIV2    = 20'd1 << 13,
      S_DIFF    = 20'd1 << 14,
      S_FMUL    = 20'd1 << 15,
      S_FUPD    = 20'd1 << 16,
      S_DEG_A   = 20'd1 << 17,
      S_DEG_F   = 20'd1 << 18,
      S_OUT     = 20'd1 << 19
   } state_type;

   // configuration registers
   logic [15:0]        supply_ff, supply_in;
   logic [19:0]        series_ff, series_in;
   logic [19:0]        pot_ff, pot_in;
   logic [8:0]         range_ff, range_in;
   logic signed [12:0] bias_ff, bias_in;
   logic [19:0]        cutoff_ff, cutoff_in;

   // sequencer and item state
   state_type             state_ff, state_in;
   logic [SAMPLE_W-1:0]   samp_ff, samp_in;
   logic [ELAPSED_W-1:0]  elap_ff, elap_in;
   logic                  over_ff, over_in;
   logic                  neg_ff, neg_in;
   logic [35:0]           a_ff, a_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [QUO_W-1:0]      num_ff, num_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic                  clamp_ff, clamp_in;
   logic [QUO_W-1:0]      xm_ff, xm_in;
   logic signed [MRAD_W-1:0] ang_ff, ang_in;
   logic signed [31:0]    filt_ff, filt_in;
   logic                  primed_ff, primed_in;
   logic [19:0]           cehi_ff, cehi_in;
   logic [DVS_W-1:0]      acc_ff, acc_in;
   logic [MUL_W-1:0]      dmag_ff, dmag_in;
   logic                  dneg_ff, dneg_in;
   logic signed [MDEG_W-1:0] mdega_ff, mdega_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [MRAD_W-1:0] out_ang_ff, out_ang_in;
   logic signed [MRAD_W-1:0] out_fm_ff, out_fm_in;
   logic signed [MDEG_W-1:0] out_mdega_ff, out_mdega_in;
   logic signed [MDEG_W-1:0] out_mdegf_ff, out_mdegf_in;
   logic                     out_over_ff, out_over_in;

   // combinational helpers
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [DVS_W:0]     trial, trial_sub;
   logic               trial_ge;
   logic [19:0]        rp;
   logic [15:0]        dvolt;
   logic [36:0]        b_val, a_val, mag, den;
   logic [63:0]        rnd_sum;
   logic [30:0]        am;
   logic signed [32:0] ang_wide;
   logic signed [32:0] diff;
   logic [33:0]        delta;
   logic [19:0]        ang_mag;
   logic [31:0]        filt_mag;
   logic [25:0]        mdega_mag;
   logic [30:0]        mdegf_mag;
   logic [24:0]        fm_mag;
   logic               req_fire;

   // configuration writes, taken in any cycle
   assign csr_ch.ready = 1'b1;

   always_comb begin
      supply_in = supply_ff;
      series_in = series_ff;
      pot_in    = pot_ff;
      range_in  = range_ff;
      bias_in   = bias_ff;
      cutoff_in = cutoff_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_SUPPLY: supply_in = csr_ch.data[15:0];
            CSR_SERIES: series_in = csr_ch.data;
            CSR_POT:    pot_in    = csr_ch.data;
            CSR_RANGE:  range_in  = csr_ch.data[8:0];
            CSR_BIAS:   bias_in   = $signed(csr_ch.data[12:0]);
            CSR_CUTOFF: cutoff_in = csr_ch.data;
            default:    supply_in = supply_ff;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // pot of zero ohms counts as one ohm
   assign rp    = (pot_ff == 20'd0) ? 20'd1 : pot_ff;
   assign dvolt = supply_ff - samp_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_A: begin
            mul_a = MUL_W'(dvolt);
            mul_b = MUL_W'(rp);
         end
         S_MUL_B: begin
            mul_a = MUL_W'(samp_ff);
            mul_b = MUL_W'(series_ff);
         end
         S_RNG: begin
            mul_a = MUL_W'(range_ff);
            mul_b = MUL_W'(MRAD_PER_DEG_Q16);
         end
         S_ANG: begin
            mul_a = MUL_W'(prod_ff[29:0]);
            mul_b = xm_ff;
         end
         S_CE: begin
            mul_a = MUL_W'(cutoff_ff);
            mul_b = MUL_W'(elap_ff);
         end
         S_PLO: begin
            mul_a = MUL_W'(prod_ff[19:0]);
            mul_b = MUL_W'(TWO_PI_Q16);
         end
         S_PHI: begin
            mul_a = MUL_W'(cehi_ff);
            mul_b = MUL_W'(TWO_PI_Q16);
         end
         S_FMUL: begin
            mul_a = {17'd0, ~quo_ff[15:0]};
            mul_b = dmag_ff;
         end
         S_DEG_A: begin
            mul_a = MUL_W'(ang_mag);
            mul_b = MUL_W'(MDEG_PER_MRAD_Q16);
         end
         // filtered product stays in place while the output step waits
         S_DEG_F, S_OUT: begin
            mul_a = MUL_W'(filt_mag);
            mul_b = MUL_W'(MDEG_PER_MRAD_Q16);
         end
         default: mul_a = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // shared restoring divide step
   assign trial     = {rem_ff, num_ff[QUO_W-1]};
   assign trial_ge  = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   // divider setup for the resistance ratio
   assign a_val = {1'b0, a_ff};
   assign b_val = {prod_ff[35:0], 1'b0};
   assign mag   = (b_val > a_val) ? (b_val - a_val) : (a_val - b_val);
   assign den   = {a_ff, 1'b0};

   // raw angle rounding and offset
   assign rnd_sum  = prod_ff[63:0] + 64'h0000_0000_8000_0000;
   assign am       = rnd_sum[62:32];
   assign ang_wide = neg_ff ? (33'(bias_ff) - $signed({2'b00, am}))
                            : (33'(bias_ff) + $signed({2'b00, am}));

   // filter error and correction
   assign diff  = $signed({{4{ang_ff[MRAD_W-1]}}, ang_ff, 8'd0}) - 33'(filt_ff);
   assign delta = 34'((prod_ff[49:0] + 50'd32768) >> 16);

   // magnitudes for the unit conversions
   assign ang_mag   = ang_ff[MRAD_W-1] ? 20'(-ang_ff) : ang_ff[19:0];
   assign filt_mag  = filt_ff[31] ? (~filt_ff + 32'd1) : filt_ff;
   assign mdega_mag = 26'((prod_ff[41:0] + 42'd32768) >> 16);
   assign mdegf_mag = 31'((prod_ff[53:0] + 54'd8388608) >> 24);
   assign fm_mag    = 25'(({1'b0, filt_mag} + 33'd128) >> 8);

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      samp_in      = samp_ff;
      elap_in      = elap_ff;
      over_in      = over_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      clamp_in     = clamp_ff;
      xm_in        = xm_ff;
      ang_in       = ang_ff;
      filt_in      = filt_ff;
      primed_in    = primed_ff;
      cehi_in      = cehi_ff;
      acc_in       = acc_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      mdega_in     = mdega_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_ang_in   = out_ang_ff;
      out_fm_in    = out_fm_ff;
      out_mdega_in = out_mdega_ff;
      out_mdegf_in = out_mdegf_ff;
      out_over_in  = out_over_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               samp_in = req_ch.sample_mv;
               elap_in = req_ch.elapsed_us;
               over_in = req_ch.sample_mv >= supply_ff;
               // at or above supply: resistance pinned to full scale
               if (req_ch.sample_mv >= supply_ff) begin
                  xm_in    = X_HALF;
                  neg_in   = 1'b1;
                  state_in = S_RNG;
               end else begin
                  state_in = S_MUL_A;
               end
            end
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: begin
            a_in     = prod_ff[35:0];
            state_in = S_DIV1_LD;
         end
         S_DIV1_LD: begin
            neg_in   = b_val > a_val;
            dvs_in   = DVS_W'(den);
            rem_in   = DVS_W'(mag[36:17]);
            clamp_in = {17'd0, mag[36:17]} >= den;
            num_in   = {mag[16:0], 16'd0};
            quo_in   = '0;
            cnt_in   = 6'd32;
            state_in = S_DIV1;
         end
         S_DIV1, S_DIV2: begin
            rem_in = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = (state_ff == S_DIV1) ? S_RNG : S_DIFF;
            end
         end
         S_RNG: begin
            if (!over_ff) begin
               xm_in = (clamp_ff || quo_ff > X_CLAMP) ? X_CLAMP : quo_ff;
            end
            state_in = S_ANG;
         end
         S_ANG: state_in = S_SAT;
         S_SAT: begin
            if (ang_wide > 33'(ANGLE_LIMIT)) begin
               ang_in = ANGLE_LIMIT;
            end else if (ang_wide < -33'(ANGLE_LIMIT)) begin
               ang_in = -ANGLE_LIMIT;
            end else begin
               ang_in = ang_wide[MRAD_W-1:0];
            end
            state_in = primed_ff ? S_CE : S_SEED;
         end
         S_SEED: begin
            filt_in   = {{3{ang_ff[MRAD_W-1]}}, ang_ff, 8'd0};
            primed_in = 1'b1;
            state_in  = S_DEG_A;
         end
         S_CE: state_in = S_PLO;
         S_PLO: begin
            cehi_in  = prod_ff[39:20];
            state_in = S_PHI;
         end
         S_PHI: begin
            acc_in   = ALPHA_BASE + DVS_W'(prod_ff[38:0]);
            state_in = S_DIV2_LD;
         end
         S_DIV2_LD: begin
            dvs_in   = acc_ff + {prod_ff[38:0], 20'd0};
            rem_in   = ALPHA_BASE - DVS_W'(1);
            num_in   = {16'hFFFF, 17'd0};
            quo_in   = '0;
            cnt_in   = 6'd15;
            state_in = S_DIV2;
         end
         S_DIFF: begin
            dneg_in  = diff[32];
            dmag_in  = diff[32] ? MUL_W'(-diff) : MUL_W'(diff);
            state_in = S_FMUL;
         end
         S_FMUL: state_in = S_FUPD;
         S_FUPD: begin
            filt_in  = dneg_ff ? (filt_ff - $signed(delta[31:0]))
                               : (filt_ff + $signed(delta[31:0]));
            state_in = S_DEG_A;
         end
         S_DEG_A: state_in = S_DEG_F;
         S_DEG_F: begin
            mdega_in = ang_ff[MRAD_W-1] ? -$signed({1'b0, mdega_mag})
                                        : $signed({1'b0, mdega_mag});
            state_in = S_OUT;
         end
         S_OUT: begin
            // load the result word once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_ang_in   = ang_ff;
               out_fm_in    = filt_ff[31] ? -$signed(MRAD_W'(fm_mag))
                                          : $signed(MRAD_W'(fm_mag));
               out_mdega_in = mdega_ff;
               out_mdegf_in = filt_ff[31] ? -$signed(MDEG_W'(mdegf_mag))
                                          : $signed(MDEG_W'(mdegf_mag));
               out_over_in  = over_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         supply_ff    <= 16'd3300;
         series_ff    <= 20'd10000;
         pot_ff       <= 20'd10000;
         range_ff     <= 9'd90;
         bias_ff      <= 13'sd0;
         cutoff_ff    <= 20'd5000;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         supply_ff    <= supply_in;
         series_ff    <= series_in;
         pot_ff       <= pot_in;
         range_ff     <= range_in;
         bias_ff      <= bias_in;
         cutoff_ff    <= cutoff_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      elap_ff      <= elap_in;
      over_ff      <= over_in;
      neg_ff       <= neg_in;
      a_ff         <= a_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      clamp_ff     <= clamp_in;
      xm_ff        <= xm_in;
      ang_ff       <= ang_in;
      filt_ff      <= filt_in;
      cehi_ff      <= cehi_in;
      acc_ff       <= acc_in;
      dmag_ff      <= dmag_in;
      dneg_ff      <= dneg_in;
      mdega_ff     <= mdega_in;
      out_ang_ff   <= out_ang_in;
      out_fm_ff    <= out_fm_in;
      out_mdega_ff <= out_mdega_in;
      out_mdegf_ff <= out_mdegf_in;
      out_over_ff  <= out_over_in;
   end

   // result channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.angle_mrad    = out_ang_ff;
   assign rsp_ch.filtered_mrad = out_fm_ff;
   assign rsp_ch.angle_mdeg    = out_mdega_ff;
   assign rsp_ch.filtered_mdeg = out_mdegf_ff;
   assign rsp_ch.over_supply   = out_over_ff;

   // divider remainder stays below the divisor while stepping, unless the ratio division is clamped
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV1 && !clamp_ff) || state_ff == S_DIV2) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   // a result word appears only out of the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result word raised outside the output step");

   // once seeded the filter stays seeded until reset
   assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("filter lost its seed");

   // the filter update runs only on a seeded filter
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CE) |-> primed_ff)
      else $error("filter update on an unseeded filter");

   // raw angle is saturated before conversion
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEG_A) |-> (ang_ff <= ANGLE_LIMIT && ang_ff >= -ANGLE_LIMIT))
      else $error("raw angle outside the saturation limit");

endmodule

FILE: dv/tb_potentiometer_angle_lowpass_unit.sv
// tb_potentiometer_angle_lowpass_unit: self-checking bench for the potentiometer angle unit
// depends on pal_pkg, the pal_req_if, pal_rsp_if and pal_csr_if channels, and the unit itself
// drives sample words and register writes, predicts each angle word and checks results in order

module tb_potentiometer_angle_lowpass_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pal_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 80;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 205;
   localparam int CALM_PHASE    = 3;
   localparam int HOLD_AT_WORD  = 40;
   localparam int IDLE_PCT      = 21;
   localparam int DIRECTED_ROWS = 18;

   // fixed-point constants of the angle math
   localparam longint unsigned DEG2MRAD_Q16  = 64'd1143819;
   localparam longint          MRAD2MDEG_Q16 = 64'sd3754936;
   localparam longint unsigned TAU_Q16       = 64'd411775;
   localparam longint unsigned ALPHA_ONE     = 64'd65536000000000;
   localparam longint unsigned RATIO_CEIL    = 64'h1_0000_0000;
   localparam longint unsigned RATIO_HALF    = 64'd32768;
   localparam longint          ANGLE_SAT     = 64'sd1000000;

   typedef struct packed {
      logic signed [MRAD_W-1:0] angle_mrad;
      logic signed [MRAD_W-1:0] filtered_mrad;
      logic signed [MDEG_W-1:0] angle_mdeg;
      logic signed [MDEG_W-1:0] filtered_mdeg;
      logic                     over_supply;
   } angle_set_type;

   typedef struct {
      logic [15:0]        vsup_mv;
      logic [19:0]        rser_ohm;
      logic [19:0]        rpot_ohm;
      logic [8:0]         span_deg;
      logic signed [12:0] offset_mrad;
      logic [19:0]        corner_mhz;
   } setting_type;

   typedef struct {
      int          setting;
      int unsigned sample;
      int unsigned elapsed;
      bit          typed;
      int          want_mrad;
      int          want_fmrad;
      int          want_mdeg;
      int          want_fmdeg;
      bit          want_over;
   } stim_row_type;

   // settings used by the directed rows; the first one equals the reset defaults
   setting_type directed_settings [3] = '{
      '{3300, 10000, 10000, 90, 0, 5000},
      '{3300, 1048575, 0, 511, -4096, 0},
      '{0, 1, 1048575, 0, 4095, 1048575}
   };

   // directed rows: setting, sample, elapsed, typed, then the typed word if any
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{0, 0, 0, 1, 785, 785, 44977, 44977, 1'b0},
      '{0, 65535, 0, 1, -785, 785, -44977, 44977, 1'b1},
      '{0, 3300, 1000, 0, 0, 0, 0, 0, 1'b0},
      '{0, 3299, 1000000, 0, 0, 0, 0, 0, 1'b0},
      '{0, 1650, 1048575, 0, 0, 0, 0, 0, 1'b0},
      '{0, 1, 1, 0, 0, 0, 0, 0, 1'b0},
      '{0, 43690, 349525, 0, 0, 0, 0, 0, 1'b0},
      '{0, 21845, 699050, 0, 0, 0, 0, 0, 1'b0},
      '{0, 1100, 20000, 0, 0, 0, 0, 0, 1'b0},
      '{0, 2200, 20000, 0, 0, 0, 0, 0, 1'b0},
      '{0, 500, 0, 0, 0, 0, 0, 0, 1'b0},
      '{1, 3299, 5000, 0, 0, 0, 0, 0, 1'b0},
      '{1, 0, 5000, 0, 0, 0, 0, 0, 1'b0},
      '{1, 3300, 5000, 0, 0, 0, 0, 0, 1'b0},
      '{1, 1, 1048575, 0, 0, 0, 0, 0, 1'b0},
      '{2, 0, 1000, 0, 0, 0, 0, 0, 1'b0},
      '{2, 65535, 1048575, 0, 0, 0, 0, 0, 1'b0},
      '{2, 12345, 0, 0, 0, 0, 0, 0, 1'b0}
   };

   logic clock;
   logic reset;

   pal_req_if req_ch ();
   pal_rsp_if rsp_ch ();
   pal_csr_if csr_ch ();

   potentiometer_angle_lowpass_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   angle_set_type      expected_angles [$];
   angle_set_type      seen_word;
   angle_set_type      oldest_word;
   setting_type        cfg_now;
   logic signed [31:0] lp_acc_q8;
   bit                 lp_seeded;
   bit                 calm = 1'b0;
   bit                 hold_pending = 1'b0;
   int                 mismatches = 0;
   int                 cycle_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // shift right with rounding half away from zero
   function automatic longint round_half_away(input longint v, input int s);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   // angle of one sample under the current setting; advances the filter state
   function automatic angle_set_type derive_angles(input logic [15:0] v_in,
                                                   input logic [19:0] e_in);
      longint unsigned v, e, vs, rp, d, a, b, den, mag, xm, t, p, dd, q;
      longint          am, ang, alpha, diff, acc;
      bit              over, neg;
      angle_set_type   r;
      v = v_in;
      e = e_in;
      vs = cfg_now.vsup_mv;
      rp = (cfg_now.rpot_ohm == 0) ? 64'd1 : 64'(cfg_now.rpot_ohm);
      over = v >= vs;
      // divider ratio (Rp - 2r) / 2Rp in Q16, magnitude and sign
      if (over) begin
         neg = 1'b1;
         xm = RATIO_HALF;
      end else begin
         d = vs - v;
         a = d * rp;
         b = 64'd2 * v * 64'(cfg_now.rser_ohm);
         den = 64'd2 * rp * d;
         neg = b > a;
         mag = neg ? b - a : a - b;
         xm = (mag << 16) / den;
         if (xm > RATIO_CEIL)
            xm = RATIO_CEIL;
      end
      // map to milliradians, offset and saturate
      t = 64'(cfg_now.span_deg) * DEG2MRAD_Q16 * xm;
      am = longint'((t + (64'd1 << 31)) >> 32);
      ang = neg ? longint'(cfg_now.offset_mrad) - am : longint'(cfg_now.offset_mrad) + am;
      if (ang > ANGLE_SAT)
         ang = ANGLE_SAT;
      if (ang < -ANGLE_SAT)
         ang = -ANGLE_SAT;
      // low-pass update, seeded by the first sample
      if (!lp_seeded) begin
         lp_acc_q8 = 32'(ang * 256);
         lp_seeded = 1'b1;
      end else begin
         p = 64'(cfg_now.corner_mhz) * e * TAU_Q16;
         dd = ALPHA_ONE + p;
         q = ((ALPHA_ONE << 16) + dd - 64'd1) / dd;
         alpha = 65536 - longint'(q);
         diff = ang * 256 - longint'(lp_acc_q8);
         acc = longint'(lp_acc_q8) + round_half_away(alpha * diff, 16);
         lp_acc_q8 = 32'(acc);
      end
      r.angle_mrad    = MRAD_W'(ang);
      r.filtered_mrad = MRAD_W'(round_half_away(longint'(lp_acc_q8), 8));
      r.angle_mdeg    = MDEG_W'(round_half_away(ang * MRAD2MDEG_Q16, 16));
      r.filtered_mdeg = MDEG_W'(round_half_away(longint'(lp_acc_q8) * MRAD2MDEG_Q16, 24));
      r.over_supply   = over;
      return r;
   endfunction

   // random setting for a phase; some phases pin the extremes
   function automatic setting_type pick_setting(input int ph);
      setting_type s;
      s.vsup_mv     = 16'($urandom_range(5000, 800));
      s.rser_ohm    = 20'($urandom_range(100000, 100));
      s.rpot_ohm    = 20'($urandom_range(100000, 100));
      s.span_deg    = 9'($urandom_range(360, 0));
      s.offset_mrad = 13'($urandom_range(6284, 0) - 3142);
      s.corner_mhz  = 20'($urandom_range(20000, 1));
      case (ph)
         1: s = '{1, 1, 1, 0, -4096, 1};
         2: s = '{65535, 1048575, 1048575, 511, 4095, 1048575};
         4: begin
            s.rpot_ohm = '0;
            s.corner_mhz = '0;
         end
         5: s = '{3300, 10000, 10000, 360, 3142, 5000};
         6: begin
            s.vsup_mv     = 16'($urandom_range(65535, 1));
            s.rser_ohm    = 20'($urandom);
            s.rpot_ohm    = 20'($urandom);
            s.span_deg    = 9'($urandom);
            s.offset_mrad = 13'($urandom);
            s.corner_mhz  = 20'($urandom);
         end
         default: ;
      endcase
      return s;
   endfunction

   // mostly below supply, some at or above it, some anywhere
   function automatic logic [15:0] draw_sample(input logic [15:0] vs);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10 || vs == 0)
         return 16'($urandom);
      if (pick < 22)
         return 16'($urandom_range(65535, vs));
      return 16'($urandom_range(vs - 1, 0));
   endfunction

   function automatic logic [19:0] draw_elapsed();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10)
         return '0;
      if (pick < 20)
         return 20'($urandom_range(100, 1));
      if (pick < 40)
         return 20'($urandom);
      return 20'($urandom_range(50000, 1000));
   endfunction

   // offer one sample word, with random gaps, and predict it once taken
   task automatic send_sample(input logic [15:0] v, input logic [19:0] e,
                              output angle_set_type pred);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.sample_mv  <= v;
      req_ch.elapsed_us <= e;
      do @(posedge clock); while (!req_ch.ready);
      pred = derive_angles(v, e);
   endtask

   // stop offering and wait until every pending result has come back
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_angles.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_SUPPLY: cfg_now.vsup_mv     = val[15:0];
         CSR_SERIES: cfg_now.rser_ohm    = val[19:0];
         CSR_POT:    cfg_now.rpot_ohm    = val[19:0];
         CSR_RANGE:  cfg_now.span_deg    = val[8:0];
         CSR_BIAS:   cfg_now.offset_mrad = val[12:0];
         CSR_CUTOFF: cfg_now.corner_mhz  = val[19:0];
         default: ;
      endcase
   endtask

   task automatic program_setting(input setting_type s);
      write_csr(CSR_SUPPLY, CSR_DAT_W'(s.vsup_mv));
      write_csr(CSR_SERIES, s.rser_ohm);
      write_csr(CSR_POT, s.rpot_ohm);
      write_csr(CSR_RANGE, CSR_DAT_W'(s.span_deg));
      write_csr(CSR_BIAS, CSR_DAT_W'(s.offset_mrad));
      write_csr(CSR_CUTOFF, s.corner_mhz);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // result ready pacing, with one long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_word.angle_mrad    = rsp_ch.angle_mrad;
         seen_word.filtered_mrad = rsp_ch.filtered_mrad;
         seen_word.angle_mdeg    = rsp_ch.angle_mdeg;
         seen_word.filtered_mdeg = rsp_ch.filtered_mdeg;
         seen_word.over_supply   = rsp_ch.over_supply;
         if (expected_angles.size() == 0) begin
            report_mismatch("result word with none pending, angle_mrad",
                            seen_word.angle_mrad, 0);
         end else begin
            oldest_word = expected_angles.pop_front();
            if (seen_word.angle_mrad !== oldest_word.angle_mrad)
               report_mismatch("angle_mrad", seen_word.angle_mrad, oldest_word.angle_mrad);
            if (seen_word.filtered_mrad !== oldest_word.filtered_mrad)
               report_mismatch("filtered_mrad", seen_word.filtered_mrad,
                               oldest_word.filtered_mrad);
            if (seen_word.angle_mdeg !== oldest_word.angle_mdeg)
               report_mismatch("angle_mdeg", seen_word.angle_mdeg, oldest_word.angle_mdeg);
            if (seen_word.filtered_mdeg !== oldest_word.filtered_mdeg)
               report_mismatch("filtered_mdeg", seen_word.filtered_mdeg,
                               oldest_word.filtered_mdeg);
            if (seen_word.over_supply !== oldest_word.over_supply)
               report_mismatch("over_supply", seen_word.over_supply, oldest_word.over_supply);
         end
      end
   end

   // stimulus: reset, directed rows, then random phases
   initial begin
      stim_row_type  row;
      setting_type   s;
      angle_set_type pred;
      logic [15:0]   v;
      logic [19:0]   e;
      int            cur;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.sample_mv  = '0;
      req_ch.elapsed_us = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_SUPPLY;
      csr_ch.data       = '0;
      cfg_now           = directed_settings[0];
      lp_acc_q8         = '0;
      lp_seeded         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, typed words where they are plain to read
      cur = 0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.setting != cur) begin
            settle();
            program_setting(directed_settings[row.setting]);
            cur = row.setting;
         end
         send_sample(row.sample[15:0], row.elapsed[19:0], pred);
         if (row.typed) begin
            pred.angle_mrad    = MRAD_W'(row.want_mrad);
            pred.filtered_mrad = MRAD_W'(row.want_fmrad);
            pred.angle_mdeg    = MDEG_W'(row.want_mdeg);
            pred.filtered_mdeg = MDEG_W'(row.want_fmdeg);
            pred.over_supply   = row.want_over;
         end
         expected_angles.push_back(pred);
      end

      // random phases, one setting each; one phase runs without gaps and holds the receiver
      for (int ph = 0; ph < PHASES; ph++) begin
         s = pick_setting(ph);
         settle();
         program_setting(s);
         calm = (ph == CALM_PHASE);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (ph == CALM_PHASE && k == HOLD_AT_WORD)
               hold_pending = 1'b1;
            v = draw_sample(s.vsup_mv);
            e = draw_elapsed();
            send_sample(v, e, pred);
            expected_angles.push_back(pred);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
